/* rtl/core/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// sfd_pkg
// shared constants and types of the stuffed frame deframer
// ----------------------------------------------------------------------------
package sfd_pkg;

  // buffer depth, byte count saturates here
  localparam int FRAME_BYTES = 32;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

  // only header (2) and payload (15) bytes are ever read back
  localparam int HDR_BYTES     = 2;
  localparam int PAY_BYTES     = 15;
  localparam int PAY_LOW_BYTES = 8;
  localparam int HOLD_BYTES    = HDR_BYTES + PAY_BYTES;
  localparam int HOLD_IDX_W    = $clog2(HOLD_BYTES);

  localparam int MIN_FRAME = 3;
  localparam logic [7:0] ESC_XOR = 8'h20;

  // reset values of the configuration registers
  localparam logic [7:0] START_RESET  = 8'h7E;
  localparam logic [7:0] ESCAPE_RESET = 8'h7D;

  // closed frame queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // register indexes
  localparam logic REG_START  = 1'b0;
  localparam logic REG_ESCAPE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_MISMATCH = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] escape_byte;
  } cfg_t;

  // snapshot of one closed frame
  typedef struct packed {
    logic [CNT_W-1:0]                count;
    logic                            overflow;
    logic [HOLD_BYTES-1:0][7:0]      bytes;
  } frame_rec_t;

endpackage

/* rtl/core/sfd_front.sv */
// ----------------------------------------------------------------------------
// sfd_front
// byte classifier: start / escape / data, unstuffing and frame collection
// ----------------------------------------------------------------------------
module sfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  sfd_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  logic              q_full,
  output logic              q_push,
  output sfd_pkg::frame_rec_t q_push_rec
);
  import sfd_pkg::*;

  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       esc_r, esc_nxt;
  logic [HOLD_BYTES-1:0][7:0] hold_r;
  logic                       acc;
  logic                       is_start;
  logic                       is_esc;
  logic                       wr_en;
  logic [7:0]                 data;

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;
  assign is_start = (in_rx_byte == cfg.start_byte);
  assign is_esc   = !is_start && (in_rx_byte == cfg.escape_byte);
  assign data     = esc_r ? (in_rx_byte ^ ESC_XOR) : in_rx_byte;

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    esc_nxt   = esc_r;
    q_push    = 1'b0;
    wr_en     = 1'b0;
    if (acc) begin
      if (is_start) begin
        q_push    = (count_r != '0);
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else if (is_esc) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        if (count_r < CNT_W'(FRAME_BYTES)) begin
          count_nxt = count_r + CNT_W'(1);
          wr_en     = (count_r < CNT_W'(HOLD_BYTES));
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end
  end

  assign q_push_rec = '{count: count_r, overflow: ovf_r, bytes: hold_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      esc_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      esc_r   <= esc_nxt;
    end
  end

  // stale bytes past the count are masked off in the back end
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hold_r[count_r[HOLD_IDX_W-1:0]] <= data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FRAME_BYTES))
    else $error("byte count beyond buffer depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (count_r == CNT_W'(FRAME_BYTES)))
    else $error("overflow flagged with buffer not full");

endmodule

/* rtl/core/sfd_fifo.sv */
// ----------------------------------------------------------------------------
// sfd_fifo
// short queue of closed frames between front and back end
// ----------------------------------------------------------------------------
module sfd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sfd_pkg::frame_rec_t push_rec,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output sfd_pkg::frame_rec_t pop_rec
);
  import sfd_pkg::*;

  frame_rec_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_rec = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? Q_PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? Q_PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("frame pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("frame popped from empty queue");

endmodule

/* rtl/core/sfd_back.sv */
// ----------------------------------------------------------------------------
// sfd_back
// frame checker: status, header decode, payload masking, output register
// ----------------------------------------------------------------------------
module sfd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  sfd_pkg::frame_rec_t q_rec,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_frame_status,
  output logic [10:0]         out_frame_address,
  output logic [3:0]          out_payload_length,
  output logic [63:0]         out_payload_low,
  output logic [55:0]         out_payload_high
);
  import sfd_pkg::*;

  logic                      valid_r, valid_nxt;
  status_t                   status_r, status_nxt;
  logic [10:0]               addr_r, addr_nxt;
  logic [3:0]                len_r, len_nxt;
  logic [PAY_BYTES-1:0][7:0] pay_r, pay_nxt;
  logic [3:0]                hdr_len;
  logic                      is_short;
  logic                      is_mismatch;

  assign q_pop = !q_empty && (!valid_r || !out_stall);

  assign hdr_len     = q_rec.bytes[1][3:0];
  assign is_short    = (q_rec.count < CNT_W'(MIN_FRAME));
  assign is_mismatch = q_rec.overflow ||
                       (q_rec.count != (CNT_W'(hdr_len) + CNT_W'(MIN_FRAME)));

  always_comb begin
    addr_nxt   = '0;
    len_nxt    = '0;
    status_nxt = ST_OK;
    if (is_short) begin
      status_nxt = ST_SHORT;
    end else begin
      addr_nxt = {q_rec.bytes[0], q_rec.bytes[1][7:5]};
      len_nxt  = hdr_len;
      if (is_mismatch) begin
        status_nxt = ST_MISMATCH;
      end
    end
    for (int i = 0; i < PAY_BYTES; i++) begin
      pay_nxt[i] = (status_nxt == ST_OK && 4'(i) < hdr_len) ?
                   q_rec.bytes[i + HDR_BYTES] : 8'h00;
    end
  end

  always_comb begin
    valid_nxt = valid_r && out_stall;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= status_nxt;
      addr_r   <= addr_nxt;
      len_r    <= len_nxt;
      pay_r    <= pay_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_frame_status   = status_r;
  assign out_frame_address  = addr_r;
  assign out_payload_length = len_r;
  assign out_payload_low    = pay_r[PAY_LOW_BYTES-1:0];
  assign out_payload_high   = pay_r[PAY_BYTES-1:PAY_LOW_BYTES];

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r == ST_SHORT) |-> (addr_r == '0 && len_r == '0))
    else $error("short frame carries header fields");

  a_bad_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r != ST_OK) |-> (pay_r == '0))
    else $error("failed frame carries payload");

endmodule

/* rtl/core/stuffed_frame_deframer.sv */
// ----------------------------------------------------------------------------
// stuffed_frame_deframer
// byte-stuffed receive deframer with escape xor and frame checking
// ----------------------------------------------------------------------------
// takes one received byte per item and accepts a new item every clock cycle
// while in_stall is low. a start byte closes a non-empty frame; the escape
// byte xors the next data byte with 0x20. each closed frame yields one result
// item with status (ok, too short, or length mismatch, also for overflow),
// 11-bit address, payload length and up to 15 payload bytes; the checksum
// byte is counted, not verified. a frame is queued at the edge that accepts
// its closing start byte and moves into the output register once that is
// free, raising out_valid. the front end only stalls its input when the
// two-entry frame queue is full, which takes three closed frames waiting
// behind a stalled output (one in the output register, two in the queue).
// start and escape bytes are programmed over the apb port at byte addresses
// 0x0 and 0x4 and must only be changed while the block is idle.
module stuffed_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // received bytes
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // checked frames
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_status,
  output logic [10:0] out_frame_address,
  output logic [3:0]  out_payload_length,
  output logic [63:0] out_payload_low,
  output logic [55:0] out_payload_high
);
  import sfd_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       reg_wr;
  logic       reg_sel;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  frame_rec_t q_push_rec;
  frame_rec_t q_pop_rec;

  // apb register file, word aligned, low address bits ignored
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (reg_wr) begin
      case (reg_sel)
        REG_START:  cfg_nxt.start_byte  = pwdata[7:0];
        REG_ESCAPE: cfg_nxt.escape_byte = pwdata[7:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_START:  prdata = {24'h0, cfg_r.start_byte};
      REG_ESCAPE: prdata = {24'h0, cfg_r.escape_byte};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{start_byte: START_RESET, escape_byte: ESCAPE_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end: classify bytes, unstuff, collect frame, snapshot on close
  sfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_push_rec (q_push_rec)
  );

  // closed frames wait here so each side can stall on its own
  sfd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_rec  (q_pop_rec)
  );

  // back end: check frame, decode header, mask payload, hold result item
  sfd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_rec              (q_pop_rec),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_status   (out_frame_status),
    .out_frame_address  (out_frame_address),
    .out_payload_length (out_payload_length),
    .out_payload_low    (out_payload_low),
    .out_payload_high   (out_payload_high)
  );

endmodule
